/* rtl/u8af_pkg.sv */
package u8af_pkg;

    // One entry of the queue between the classifier and the output side.
    // It holds up to two characters; a single character always sits in slot 0.
    typedef struct packed {
        logic [6:0] ch0;
        logic       val0;
        logic       two;
        logic [6:0] ch1;
        logic       eos;
    } q_entry_t;

    localparam logic [20:0] CP_EN_DASH     = 21'h02013;
    localparam logic [20:0] CP_EM_DASH     = 21'h02014;
    localparam logic [20:0] CP_LEFT_SQUOTE = 21'h02018;
    localparam logic [20:0] CP_RIGHT_SQUOTE = 21'h02019;
    localparam logic [20:0] CP_LEFT_DQUOTE = 21'h0201C;
    localparam logic [20:0] CP_RIGHT_DQUOTE = 21'h0201D;
    localparam logic [20:0] CP_ASCII_LIMIT = 21'h00080;

    localparam logic [6:0] ASCII_DASH  = 7'h2D;
    localparam logic [6:0] ASCII_APOS  = 7'h27;
    localparam logic [6:0] ASCII_QUOTE = 7'h22;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_ONE  = 3'd1;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    function automatic logic [6:0] fold_cp(input logic [20:0] cp);
        logic [6:0] c;
        begin
            if (cp == CP_EN_DASH || cp == CP_EM_DASH)
            begin
                c = ASCII_DASH;
            end
            else if (cp == CP_LEFT_SQUOTE || cp == CP_RIGHT_SQUOTE)
            begin
                c = ASCII_APOS;
            end
            else if (cp == CP_LEFT_DQUOTE || cp == CP_RIGHT_DQUOTE)
            begin
                c = ASCII_QUOTE;
            end
            else if (cp < CP_ASCII_LIMIT)
            begin
                c = cp[6:0];
            end
            else
            begin
                c = 7'd0;
            end
            return c;
        end
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] l;
        begin
            if ((b & LEAD2_MASK) == LEAD2_CODE)
            begin
                l = SEQ_TWO;
            end
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
            begin
                l = SEQ_THREE;
            end
            else if ((b & LEAD4_MASK) == LEAD4_CODE)
            begin
                l = SEQ_FOUR;
            end
            else
            begin
                l = SEQ_ONE;
            end
            return l;
        end
    endfunction

    // A lone byte: ASCII passes, anything at or above 0x80 folds to nothing.
    function automatic logic [6:0] ascii_of(input logic [7:0] b);
        return b[7] ? 7'd0 : b[6:0];
    endfunction

endpackage

/* rtl/u8af_front.sv */
module u8af_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 q_ready,
    output logic                 q_push,
    output u8af_pkg::q_entry_t   q_entry
);
    import u8af_pkg::*;

    logic [7:0]  pend_reg [0:2];
    logic [1:0]  count_reg, count_next;
    logic [2:0]  seq_len_reg, seq_len_next;
    logic        accept;
    logic        seq_open;
    logic        complete;
    logic [2:0]  cnt_inc;
    logic [20:0] asm_cp;
    logic [20:0] pair_cp;
    logic [6:0]  ca, cb;
    logic        va, vb;
    logic        pend_we;
    logic [1:0]  pend_idx;

    assign in_ready = q_ready;
    assign accept   = in_valid & q_ready;
    assign seq_open = (seq_len_reg != SEQ_NONE);
    assign cnt_inc  = {1'b0, count_reg} + 3'd1;
    assign complete = seq_open && (cnt_inc >= seq_len_reg);

    always_comb
    begin
        case (seq_len_reg)
            SEQ_TWO:   asm_cp = {10'd0, pend_reg[0][4:0], in_byte[5:0]};
            SEQ_THREE: asm_cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], in_byte[5:0]};
            default:   asm_cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                                 in_byte[5:0]};
        endcase
    end

    assign pair_cp = {10'd0, pend_reg[1][4:0], in_byte[5:0]};

    // Candidate characters. On a final byte inside an unfinished sequence the
    // lead byte is dropped and the held continuation is decoded once more.
    always_comb
    begin
        ca = ascii_of(in_byte);
        cb = 7'd0;
        if (seq_open)
        begin
            if (complete)
            begin
                ca = fold_cp(asm_cp);
            end
            else if (count_reg == 2'd2)
            begin
                if (!pend_reg[1][7])
                begin
                    ca = pend_reg[1][6:0];
                    cb = ascii_of(in_byte);
                end
                else if (lead_len(pend_reg[1]) == SEQ_TWO)
                begin
                    ca = fold_cp(pair_cp);
                end
                else
                begin
                    ca = ascii_of(in_byte);
                end
            end
            else
            begin
                ca = ascii_of(in_byte);
            end
        end
    end

    assign va = (ca != 7'd0);
    assign vb = (cb != 7'd0);

    always_comb
    begin
        q_entry.ch0  = va ? ca : cb;
        q_entry.val0 = va | vb;
        q_entry.two  = va & vb;
        q_entry.ch1  = cb;
        q_entry.eos  = in_last;
    end

    assign q_push = accept & (in_last | (va & (!seq_open | complete)));

    always_comb
    begin
        count_next   = count_reg;
        seq_len_next = seq_len_reg;
        pend_we      = 1'b0;
        pend_idx     = count_reg;
        if (accept)
        begin
            if (in_last || complete)
            begin
                count_next   = 2'd0;
                seq_len_next = SEQ_NONE;
            end
            else if (seq_open)
            begin
                pend_we    = 1'b1;
                count_next = count_reg + 2'd1;
            end
            else if (in_byte[7] && lead_len(in_byte) != SEQ_ONE)
            begin
                pend_we      = 1'b1;
                pend_idx     = 2'd0;
                count_next   = 2'd1;
                seq_len_next = lead_len(in_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 2'd0;
            seq_len_reg <= SEQ_NONE;
        end
        else
        begin
            count_reg   <= count_next;
            seq_len_reg <= seq_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_reg[pend_idx] <= in_byte;
        end
    end

endmodule

/* rtl/u8af_queue.sv */
module u8af_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 in_ready,
    input  u8af_pkg::q_entry_t   in_entry,
    output logic                 out_valid,
    input  logic                 pop,
    output u8af_pkg::q_entry_t   out_entry
);
    import u8af_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign do_push   = push & in_ready;
    assign do_pop    = pop & out_valid;
    assign out_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

/* rtl/u8af_back.sv */
module u8af_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  u8af_pkg::q_entry_t   q_entry,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [6:0]           out_char,
    output logic                 out_char_valid,
    output logic                 out_eos
);
    import u8af_pkg::*;

    logic       sub_reg, sub_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       cval_reg, cval_next;
    logic       eos_reg, eos_next;
    logic       load;

    assign load = q_valid & (!valid_reg | out_ready);

    // An entry with two characters is sent over two words; the queue head
    // is released only with its last word.
    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg & !out_ready;
        char_next  = char_reg;
        cval_next  = cval_reg;
        eos_next   = eos_reg;
        q_pop      = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (sub_reg)
            begin
                char_next = q_entry.ch1;
                cval_next = 1'b1;
                eos_next  = q_entry.eos;
                sub_next  = 1'b0;
                q_pop     = 1'b1;
            end
            else
            begin
                char_next = q_entry.ch0;
                cval_next = q_entry.val0;
                eos_next  = q_entry.eos & !q_entry.two;
                sub_next  = q_entry.two;
                q_pop     = !q_entry.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        cval_reg <= cval_next;
        eos_reg  <= eos_next;
    end

    assign out_valid      = valid_reg;
    assign out_char       = char_reg;
    assign out_char_valid = cval_reg;
    assign out_eos        = eos_reg;

endmodule

/* rtl/utf8_to_ascii_fold_core.sv */
// A taken byte's character is first written into the queue and then loaded into the output
// register, once no earlier word is waiting ahead of it.
// Throughput: one byte per cycle; a final byte that yields two characters holds the
// output side for a second word, which the queue between classifier and output absorbs.
// The classifier stalls only when that queue is full.
// Reset: rst_n is asynchronous and active low; it empties the queue, drops any open
// sequence and drops the output word. Held sequence bytes are not cleared.
module utf8_to_ascii_fold_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic [0:0] m_axis_tuser,   // [0] char_valid
    output logic       m_axis_tlast
);
    import u8af_pkg::*;

    logic     q_push, q_ready, q_valid, q_pop;
    q_entry_t q_in_entry, q_out_entry;
    logic [6:0] out_char;
    logic       out_char_valid;

    u8af_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (q_in_entry)
    );

    u8af_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .in_ready  (q_ready),
        .in_entry  (q_in_entry),
        .out_valid (q_valid),
        .pop       (q_pop),
        .out_entry (q_out_entry)
    );

    u8af_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_entry        (q_out_entry),
        .q_pop          (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_char       (out_char),
        .out_char_valid (out_char_valid),
        .out_eos        (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};
    assign m_axis_tuser = out_char_valid;

`ifndef SYNTHESIS
    // A word without a character is only ever the bare end marker.
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'd0)
        else $error("word without character is not a bare end marker");

    // NUL and dropped code points never reach the output as characters.
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != 8'd0)
        else $error("character word carries NUL");

    // The output side never releases a queue entry that is not there.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule
